@@ src/kcl_pkg.sv @@
// ----------------------------------------------------------------------------
// Keypad combination lock package
// Shared types, state codes and reset values for the combination lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

    localparam int KeyW   = 4;
    localparam int MatrixW = 16;
    localparam int StepW  = 3;
    localparam int DigitCount = 5;
    localparam int CodeW  = KeyW * DigitCount;

    // Entry step codes.
    localparam logic [StepW-1:0] STEP_IDLE   = 3'd0;
    localparam logic [StepW-1:0] STEP_ARMED  = 3'd1;
    localparam logic [StepW-1:0] STEP_DIG1   = 3'd2;
    localparam logic [StepW-1:0] STEP_DIG2   = 3'd3;
    localparam logic [StepW-1:0] STEP_DIG3   = 3'd4;
    localparam logic [StepW-1:0] STEP_DIG4   = 3'd5;
    localparam logic [StepW-1:0] STEP_DIG5   = 3'd6;
    localparam logic [StepW-1:0] STEP_BEFORE = 3'd7;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_KEY = 2'd0;
    localparam logic [1:0] CFG_CODE_KEYS = 2'd1;

    localparam logic [KeyW-1:0]  START_KEY_RESET = 4'd11;
    localparam logic [CodeW-1:0] CODE_KEYS_RESET = 20'h51840;

    typedef struct packed {
        logic            valid;
        logic [KeyW-1:0] index;
    } key_t;

    typedef struct packed {
        logic [StepW-1:0] step;
        logic             unlocked;
        logic             progress;
        logic             idle;
    } lock_status_t;

endpackage

@@ src/kcl_key_decode.sv @@
// ----------------------------------------------------------------------------
// Keypad priority decoder
// Picks the lowest-indexed pressed key of the 4x4 matrix snapshot.
// ----------------------------------------------------------------------------
module kcl_key_decode
    import kcl_pkg::*;
(
    input  logic [MatrixW-1:0] key_matrix,
    output key_t               key
);

    always_comb begin
        key.valid = |key_matrix;
        key.index = '0;
        // Scan from the top so the lowest set bit is the last one to win.
        for (int i = MatrixW - 1; i >= 0; i--) begin
            if (key_matrix[i]) begin
                key.index = KeyW'(i);
            end
        end
    end

endmodule

@@ src/kcl_entry_fsm.sv @@
// ----------------------------------------------------------------------------
// Code entry state machine
// Tracks the entry step and LED flags; advances once per processed request.
// ----------------------------------------------------------------------------
module kcl_entry_fsm
    import kcl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  key_t             key,
    input  logic             lock_button,
    input  logic [KeyW-1:0]  start_key,
    input  logic [CodeW-1:0] code_keys,
    output lock_status_t     status_next
);

    logic [StepW-1:0] step_reg;
    logic             unlocked_reg;
    logic             progress_reg;
    logic             idle_reg;

    logic [StepW-1:0] step_next;
    logic             unlocked_next;
    logic             progress_next;
    logic             idle_next;
    logic [KeyW-1:0]  want;
    logic             is_start;

    assign is_start = key.valid && (key.index == start_key);

    always_comb begin
        case (step_reg)
            STEP_ARMED: want = code_keys[0*KeyW +: KeyW];
            STEP_DIG1:  want = code_keys[1*KeyW +: KeyW];
            STEP_DIG2:  want = code_keys[2*KeyW +: KeyW];
            STEP_DIG3:  want = code_keys[3*KeyW +: KeyW];
            STEP_DIG4:  want = code_keys[4*KeyW +: KeyW];
            default:    want = '0;
        endcase
    end

    always_comb begin
        case (step_reg)
            STEP_BEFORE, STEP_DIG5: step_next = STEP_IDLE;
            STEP_IDLE: step_next = is_start ? STEP_ARMED : STEP_IDLE;
            default: begin
                // The start key wins over a code digit of the same value.
                if (is_start) begin
                    step_next = STEP_ARMED;
                end else if (!key.valid) begin
                    step_next = step_reg;
                end else if (key.index == want) begin
                    step_next = step_reg + 3'd1;
                end else begin
                    step_next = STEP_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        unlocked_next = unlocked_reg;
        progress_next = progress_reg;
        idle_next     = idle_reg;
        case (step_next)
            STEP_IDLE:  idle_next = 1'b1;
            STEP_ARMED: begin
                progress_next = 1'b1;
                idle_next     = 1'b0;
            end
            STEP_DIG1:  progress_next = 1'b0;
            STEP_DIG2:  progress_next = 1'b1;
            STEP_DIG3:  progress_next = 1'b0;
            STEP_DIG4:  progress_next = 1'b1;
            STEP_DIG5: begin
                unlocked_next = 1'b1;
                progress_next = 1'b0;
            end
            default: ;
        endcase
        if (lock_button) begin
            unlocked_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= STEP_BEFORE;
            unlocked_reg <= 1'b0;
            progress_reg <= 1'b0;
            idle_reg     <= 1'b0;
        end else if (advance) begin
            step_reg     <= step_next;
            unlocked_reg <= unlocked_next;
            progress_reg <= progress_next;
            idle_reg     <= idle_next;
        end
    end

    assign status_next.step     = step_next;
    assign status_next.unlocked = unlocked_next;
    assign status_next.progress = progress_next;
    assign status_next.idle     = idle_next;

endmodule

@@ src/keypad_combination_lock.sv @@
// An accepted input request passes the input register, then the result register, to m_tvalid.
// Throughput: one request per cycle unless m_tready stalls the result; an input
// register and a result register bracket the key decode and entry state machine,
// so both sides may stream. Reset (aresetn low, synchronous): channels empty, entry
// step before first tick, LED flags clear, start_key 11 and code_keys 0x51840.
// ----------------------------------------------------------------------------
// Keypad combination lock
// Decodes keypad snapshots and runs the combination entry machine.
// ----------------------------------------------------------------------------
module keypad_combination_lock
    import kcl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // key_matrix[15:0], lock_button[16], zero[23:17]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // key_valid[0], key_index[4:1], entry_step[7:5],
                                   // unlocked_led[8], progress_led[9], idle_led[10],
                                   // zero[15:11]
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic               in_valid_reg;
    logic [MatrixW-1:0] in_matrix_reg;
    logic               in_button_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;
    logic [KeyW-1:0]    start_key_reg;
    logic [CodeW-1:0]   code_keys_reg;

    logic               out_free;
    logic               advance;
    key_t               key;
    lock_status_t       status_next;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_key_reg <= START_KEY_RESET;
            code_keys_reg <= CODE_KEYS_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_START_KEY: start_key_reg <= cfg_data[KeyW-1:0];
                CFG_CODE_KEYS: code_keys_reg <= cfg_data[CodeW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_matrix_reg <= s_tdata[MatrixW-1:0];
            in_button_reg <= s_tdata[MatrixW];
        end
    end

    kcl_key_decode u_decode (
        .key_matrix (in_matrix_reg),
        .key        (key)
    );

    kcl_entry_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .key         (key),
        .lock_button (in_button_reg),
        .start_key   (start_key_reg),
        .code_keys   (code_keys_reg),
        .status_next (status_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {5'b0, status_next.idle, status_next.progress,
                             status_next.unlocked, status_next.step,
                             key.index, key.valid};
        end
    end

endmodule

@@ src/kcl_checker.sv @@
// ----------------------------------------------------------------------------
// Keypad combination lock checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module kcl_checker
    import kcl_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled result must hold until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Without a pressed key the reported index is zero.
    a_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[4:1] == 4'd0)
        else $error("key index nonzero without a key");

    // The first processed request always leaves the before-first-tick step.
    a_no_before: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:5] != STEP_BEFORE)
        else $error("entry step shows before-first-tick");

    // Idle lights the idle LED; armed lights progress and clears idle.
    a_leds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:5] != STEP_IDLE || m_tdata[10]) &&
                     (m_tdata[7:5] != STEP_ARMED || (m_tdata[9] && !m_tdata[10])))
        else $error("LED flags disagree with entry step");

endmodule

bind keypad_combination_lock kcl_checker u_kcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ bench/tb_keypad_combination_lock.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad combination lock testbench
// Streams keypad snapshots through the lock, mirrors the key decode and the
// code-entry machine in a scoreboard, and checks every status result field
// by field. The code registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_keypad_combination_lock;
    import kcl_pkg::*;

    typedef struct {
        key_t         key;
        lock_status_t status;
    } lock_view_t;

    class lock_tracker;
        logic [KeyW-1:0]  start_key;
        logic [CodeW-1:0] code_keys;
        logic [StepW-1:0] step;
        logic             unlocked;
        logic             progress;
        logic             idle_lit;
        lock_view_t       expected_status[$];
        int               mismatches;

        function new();
            start_key  = START_KEY_RESET;
            code_keys  = CODE_KEYS_RESET;
            step       = STEP_BEFORE;
            unlocked   = 1'b0;
            progress   = 1'b0;
            idle_lit   = 1'b0;
            mismatches = 0;
        endfunction

        function void write_register(logic [1:0] index, logic [CodeW-1:0] data);
            if (index == CFG_START_KEY) begin
                start_key = data[KeyW-1:0];
            end else if (index == CFG_CODE_KEYS) begin
                code_keys = data;
            end
        endfunction

        // Advance the entry machine by one keypad snapshot and queue its status.
        function void note_keys(logic [MatrixW-1:0] matrix, logic button);
            key_t             key;
            logic [StepW-1:0] nxt;
            lock_view_t       view;
            key.valid = |matrix;
            key.index = '0;
            for (int i = MatrixW - 1; i >= 0; i--) begin
                if (matrix[i]) key.index = i[KeyW-1:0];
            end

            if (step == STEP_BEFORE || step == STEP_DIG5) begin
                nxt = STEP_IDLE;
            end else if (key.valid && key.index == start_key) begin
                nxt = STEP_ARMED;
            end else if (step == STEP_IDLE) begin
                nxt = STEP_IDLE;
            end else if (!key.valid) begin
                nxt = step;
            end else if (key.index == code_keys[(int'(step) - 1) * KeyW +: KeyW]) begin
                nxt = step + 3'd1;
            end else begin
                nxt = STEP_IDLE;
            end
            step = nxt;

            case (step)
                STEP_IDLE: begin
                    idle_lit = 1'b1;
                end
                STEP_ARMED: begin
                    progress = 1'b1;
                    idle_lit = 1'b0;
                end
                STEP_DIG1, STEP_DIG3: progress = 1'b0;
                STEP_DIG2, STEP_DIG4: progress = 1'b1;
                STEP_DIG5: begin
                    unlocked = 1'b1;
                    progress = 1'b0;
                end
                default: ;
            endcase
            if (button) unlocked = 1'b0;

            view.key             = key;
            view.status.step     = step;
            view.status.unlocked = unlocked;
            view.status.progress = progress;
            view.status.idle     = idle_lit;
            expected_status.push_back(view);
        endfunction

        function void check_status(logic [15:0] tdata);
            lock_view_t want;
            if (expected_status.size() == 0) begin
                $error("status result 0x%h arrived with no request outstanding", tdata);
                mismatches++;
                return;
            end
            want = expected_status.pop_front();
            if (tdata[0] !== want.key.valid) begin
                $error("key_valid: expected %0d, got %0d", want.key.valid, tdata[0]);
                mismatches++;
            end
            if (tdata[4:1] !== want.key.index) begin
                $error("key_index: expected %0d, got %0d", want.key.index, tdata[4:1]);
                mismatches++;
            end
            if (tdata[7:5] !== want.status.step) begin
                $error("entry_step: expected %0d, got %0d", want.status.step, tdata[7:5]);
                mismatches++;
            end
            if (tdata[8] !== want.status.unlocked) begin
                $error("unlocked_led: expected %0d, got %0d", want.status.unlocked, tdata[8]);
                mismatches++;
            end
            if (tdata[9] !== want.status.progress) begin
                $error("progress_led: expected %0d, got %0d", want.status.progress, tdata[9]);
                mismatches++;
            end
            if (tdata[10] !== want.status.idle) begin
                $error("idle_led: expected %0d, got %0d", want.status.idle, tdata[10]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;    // key_matrix[15:0], lock_button[16], zero[23:17]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // key_valid[0], key_index[4:1], entry_step[7:5],
                                    // unlocked_led[8], progress_led[9], idle_led[10]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [19:0] cfg_data  = '0;

    lock_tracker      sb;
    bit               calm = 1'b0;
    int               sent = 0;
    logic [KeyW-1:0]  cur_start = START_KEY_RESET;
    logic [CodeW-1:0] cur_code  = CODE_KEYS_RESET;

    keypad_combination_lock dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 17);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_status(m_tdata);
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // One pressed key, optionally with extra keys of lower priority held too.
    function automatic logic [MatrixW-1:0] key_bits(int k, bit noisy);
        logic [MatrixW-1:0] m;
        logic [MatrixW-1:0] above;
        m     = 16'd1 << k;
        above = ~((m << 1) - 16'd1);
        if (noisy) m = m | (16'($urandom) & above);
        return m;
    endfunction

    function automatic logic rand_button();
        return $urandom_range(99) < 15;
    endfunction

    task automatic send_keys(input logic [MatrixW-1:0] matrix, input logic button);
        while (!calm && $urandom_range(99) < 17) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, button, matrix};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_keys(matrix, button);
        sent++;
    endtask

    task automatic press(input int k, input logic button);
        send_keys(key_bits(k, $urandom_range(99) < 30), button);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [19:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.write_register(index, data);
        if (index == CFG_START_KEY) cur_start = data[KeyW-1:0];
        else if (index == CFG_CODE_KEYS) cur_code = data;
    endtask

    // Stop sending and let every outstanding status come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Start key, then up to five digits, with holds and stray keys mixed in.
    task automatic code_attempt(input int depth);
        press(cur_start, rand_button());
        for (int d = 0; d < depth; d++) begin
            if ($urandom_range(99) < 15) send_keys('0, rand_button());
            if ($urandom_range(99) < 6) begin
                press($urandom_range(15), rand_button());
            end else begin
                press(cur_code[d * KeyW +: KeyW], rand_button());
            end
        end
    endtask

    task automatic run_random(input int n);
        int target;
        int r;
        target = sent + n;
        while (sent < target) begin
            r = $urandom_range(99);
            if (r < 70) begin
                code_attempt(DigitCount);
            end else if (r < 82) begin
                code_attempt($urandom_range(DigitCount - 1));
            end else if (r < 88) begin
                send_keys('0, rand_button());
            end else begin
                send_keys(16'($urandom), rand_button());
            end
        end
    endtask

    task automatic directed();
        send_keys('0, 1'b0);
        send_keys(16'hFFFF, 1'b1);
        press(cur_start, 1'b0);
        press(0, 1'b0);
        send_keys('0, 1'b0);
        press(4, 1'b0);
        send_keys(key_bits(cur_start, 1'b1), 1'b0);
        press(0, 1'b0);
        press(4, 1'b0);
        press(8, 1'b0);
        press(1, 1'b0);
        press(5, 1'b0);
        send_keys(16'h8000, 1'b0);
        send_keys('0, 1'b1);
        press(cur_start, 1'b0);
        press(0, 1'b0);
        press(4, 1'b0);
        press(8, 1'b0);
        press(1, 1'b0);
        press(5, 1'b1);
        press(cur_start, 1'b0);
        press(3, 1'b0);
    endtask

    initial begin
        logic [KeyW-1:0]  sk;
        logic [CodeW-1:0] code;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed();
        run_random(271);
        drain();

        write_register(CFG_START_KEY, 20'hFFFF0);
        write_register(CFG_CODE_KEYS, 20'h00000);
        run_random(271);
        drain();

        write_register(CFG_START_KEY, 20'h0000F);
        write_register(CFG_CODE_KEYS, 20'hFFFFF);
        run_random(271);
        drain();

        // A code digit equal to the start key always re-arms the entry.
        sk   = 4'($urandom);
        code = 20'($urandom);
        code[$urandom_range(DigitCount - 1) * KeyW +: KeyW] = sk;
        write_register(CFG_START_KEY, {16'($urandom), sk});
        write_register(CFG_CODE_KEYS, code);
        write_register(2'd2, 20'($urandom));
        write_register(2'd3, 20'($urandom));
        calm = 1'b1;
        run_random(271);
        calm = 1'b0;
        drain();

        for (int p = 0; p < 2; p++) begin
            write_register(CFG_START_KEY, 20'($urandom));
            write_register(CFG_CODE_KEYS, 20'($urandom));
            run_random(271);
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/kcl_pkg.sv
src/kcl_key_decode.sv
src/kcl_entry_fsm.sv
src/keypad_combination_lock.sv
src/kcl_checker.sv
bench/tb_keypad_combination_lock.sv
